[rtl/frame_blit_color_key_unit_macros.svh]
// Assertion macros for the color-key blitter.
// Each macro takes a label, the clock, the active-low reset, a trigger and a consequence.
`ifndef FRAME_BLIT_COLOR_KEY_UNIT_MACROS_SVH
`define FRAME_BLIT_COLOR_KEY_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// consequence holds in the same cycle as the trigger
`define FBCK_ASSERT_NOW(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cons)) \
		else $error("assertion failed: trigger without consequence");

// consequence holds in the cycle after the trigger
`define FBCK_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cons)) \
		else $error("assertion failed: consequence missing in next cycle");

`else

`define FBCK_ASSERT_NOW(label, clk, rst_n, trig, cons)
`define FBCK_ASSERT_NEXT(label, clk, rst_n, trig, cons)

`endif

`endif

[rtl/fbck_pkg.sv]
`default_nettype none

package fbck_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_KEY_ENABLE = 3'd6;

	// field widths
	localparam int DIM_W   = 7;
	localparam int ORG_W   = 6;
	localparam int COLOR_W = 24;
	localparam int RADDR_W = 12;
	// ty * width + tx with both coordinates below 128
	localparam int IDX_W   = 14;

	// input kind codes
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// target position of the current source pixel
	typedef struct packed {
		logic [DIM_W-1:0] tx;
		logic [DIM_W-1:0] ty;
		logic             in_frame;
		logic             done;
	} fbck_pos_t;

endpackage

`default_nettype wire

[rtl/fbck_ram.sv]
`default_nettype none

module fbck_ram #(
	parameter int WIDTH  = 24,
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/fbck_cursor.sv]
`default_nettype none

module fbck_cursor
	import fbck_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             restart,
	input  wire logic             advance,
	input  wire logic [DIM_W-1:0] target_width,
	input  wire logic [DIM_W-1:0] target_height,
	input  wire logic [ORG_W-1:0] origin_x,
	input  wire logic [ORG_W-1:0] origin_y,
	input  wire logic [DIM_W-1:0] source_width,
	input  wire logic [DIM_W-1:0] source_height,
	output fbck_pos_t             pos
);

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int SWX_W = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
	localparam int SHX_W = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;
	localparam int TX_W  = ((COL_W > ORG_W) ? COL_W : ORG_W) + 1;
	localparam int TY_W  = ((ROW_W > ORG_W) ? ROW_W : ORG_W) + 1;
	localparam int CX_W  = (TX_W > DIM_W) ? TX_W : DIM_W;
	localparam int CY_W  = (TY_W > DIM_W) ? TY_W : DIM_W;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [SWX_W-1:0] src_w, sw_eff, col_next;
	logic [SHX_W-1:0] src_h, sh_eff, row_next;
	logic             col_wrap, row_wrap;
	logic [TX_W-1:0]  tx;
	logic [TY_W-1:0]  ty;

	// source size clamped to 1..MAX
	always_comb begin
		src_w = SWX_W'(source_width);
		src_h = SHX_W'(source_height);
		if (src_w == '0) begin
			sw_eff = SWX_W'(1);
		end else if (src_w > SWX_W'(MAX_WIDTH)) begin
			sw_eff = SWX_W'(MAX_WIDTH);
		end else begin
			sw_eff = src_w;
		end
		if (src_h == '0) begin
			sh_eff = SHX_W'(1);
		end else if (src_h > SHX_W'(MAX_HEIGHT)) begin
			sh_eff = SHX_W'(MAX_HEIGHT);
		end else begin
			sh_eff = src_h;
		end
	end

	assign col_next = SWX_W'(col_q) + SWX_W'(1);
	assign row_next = SHX_W'(row_q) + SHX_W'(1);
	assign col_wrap = col_next >= sw_eff;
	assign row_wrap = row_next >= sh_eff;

	// target position and clip test
	assign tx = TX_W'(origin_x) + TX_W'(col_q);
	assign ty = TY_W'(origin_y) + TY_W'(row_q);

	assign pos.tx       = tx[DIM_W-1:0];
	assign pos.ty       = ty[DIM_W-1:0];
	assign pos.in_frame = (CX_W'(tx) < CX_W'(target_width)) &&
	                      (CY_W'(ty) < CY_W'(target_height));
	assign pos.done     = col_wrap && row_wrap;

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q <= '0;
				end else begin
					row_q <= row_next[ROW_W-1:0];
				end
			end else begin
				col_q <= col_next[COL_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

[rtl/frame_blit_color_key_unit.sv]
`default_nettype none
`include "frame_blit_color_key_unit_macros.svh"

// Color-key rectangle blitter into a frame store. Each input word is either a
// source pixel (kind 0), placed by internal raster counters at origin plus
// column/row, clipped to the target frame and skipped when black with the key
// enabled, or a read of one stored pixel (kind 1). Every input word gives exactly
// one result word. The block takes one word per clock while the output is not
// stalled by out_ready. Stage 1 forms the store index (one small multiply) and
// issues the store write or read; stage 2 holds the result with the registered
// read of the store. A configuration write to a defined index (0 to 6) restarts
// the rectangle at its top-left pixel; write configuration only while no word is
// in flight. Store entries must be written before they are read.
module frame_blit_color_key_unit
	import fbck_pkg::*;
#(
	parameter int MAX_WIDTH   = 64,
	parameter int MAX_HEIGHT  = 64,
	parameter int STORE_DEPTH = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  kind,
	input  wire logic [COLOR_W-1:0]    pixel_color,
	input  wire logic [RADDR_W-1:0]    read_address,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [COLOR_W-1:0]    read_color,
	output logic                       landed,
	output logic                       rect_done
);

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	// configuration registers
	logic [DIM_W-1:0] target_width_q, target_height_q, source_width_q, source_height_q;
	logic [ORG_W-1:0] origin_x_q, origin_y_q;
	logic             key_en_q;
	logic             restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_width_q  <= DIM_W'(32);
			target_height_q <= DIM_W'(32);
			origin_x_q      <= '0;
			origin_y_q      <= '0;
			source_width_q  <= DIM_W'(1);
			source_height_q <= DIM_W'(1);
			key_en_q        <= 1'b0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_TARGET_WIDTH:     target_width_q  <= cfg_data;
				CFG_TARGET_HEIGHT:    target_height_q <= cfg_data;
				CFG_ORIGIN_X:         origin_x_q      <= cfg_data[ORG_W-1:0];
				CFG_ORIGIN_Y:         origin_y_q      <= cfg_data[ORG_W-1:0];
				CFG_SOURCE_WIDTH:     source_width_q  <= cfg_data;
				CFG_SOURCE_HEIGHT:    source_height_q <= cfg_data;
				CFG_COLOR_KEY_ENABLE: key_en_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign restart = cfg_write_en && (cfg_index <= CFG_COLOR_KEY_ENABLE);

	// pipeline control
	logic valid_s1, valid_s2;
	logic adv_s1, load_s2, in_fire;

	assign load_s2  = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && load_s2;
	assign in_ready = !valid_s1 || load_s2;
	assign in_fire  = in_valid && in_ready;

	// raster position of the next source pixel
	fbck_pos_t pos;

	fbck_cursor #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cursor (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (restart),
		.advance       (in_fire && (kind == KIND_PIXEL)),
		.target_width  (target_width_q),
		.target_height (target_height_q),
		.origin_x      (origin_x_q),
		.origin_y      (origin_y_q),
		.source_width  (source_width_q),
		.source_height (source_height_q),
		.pos           (pos)
	);

	// stage 1: captured word with its target position
	logic               kind_s1, hit_s1, done_s1;
	logic [COLOR_W-1:0] color_s1;
	logic [RADDR_W-1:0] addr_s1;
	logic [DIM_W-1:0]   tx_s1, ty_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1  <= kind;
			color_s1 <= pixel_color;
			addr_s1  <= read_address;
			tx_s1    <= pos.tx;
			ty_s1    <= pos.ty;
			hit_s1   <= pos.in_frame && !(key_en_q && (pixel_color == '0));
			done_s1  <= pos.done && (kind == KIND_PIXEL);
		end
	end

	// store index and range checks
	logic [IDX_W-1:0]    idx;
	logic [IDX_W+AW-1:0] idx_wide;
	logic [RADDR_W+AW-1:0] raddr_wide;
	logic                idx_ok, raddr_ok, land_s1;
	logic                wr_en, rd_en;

	assign idx        = IDX_W'(ty_s1) * IDX_W'(target_width_q) + IDX_W'(tx_s1);
	assign idx_ok     = 32'(idx) < 32'(STORE_DEPTH);
	assign raddr_ok   = 32'(addr_s1) < 32'(STORE_DEPTH);
	assign idx_wide   = {{AW{1'b0}}, idx};
	assign raddr_wide = {{AW{1'b0}}, addr_s1};
	assign land_s1    = (kind_s1 == KIND_PIXEL) && hit_s1 && idx_ok;
	assign wr_en      = adv_s1 && land_s1;
	assign rd_en      = adv_s1 && (kind_s1 == KIND_READ);

	logic [COLOR_W-1:0] rd_data;

	fbck_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (idx_wide[AW-1:0]),
		.wr_data (color_s1),
		.rd_en   (rd_en),
		.rd_addr (raddr_wide[AW-1:0]),
		.rd_data (rd_data)
	);

	// stage 2: result word
	logic kind_s2, landed_s2, done_s2, rd_ok_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind_s2   <= kind_s1;
			landed_s2 <= land_s1;
			done_s2   <= done_s1;
			rd_ok_s2  <= raddr_ok;
		end
	end

	assign out_valid  = valid_s2;
	assign read_color = ((kind_s2 == KIND_READ) && rd_ok_s2) ? rd_data : '0;
	assign landed     = landed_s2;
	assign rect_done  = done_s2;

	// checks
	`FBCK_ASSERT_NOW(a_read_no_flags, clk, arst_n, valid_s2 && (kind_s2 == KIND_READ), !landed && !rect_done)
	`FBCK_ASSERT_NOW(a_write_only_pixel, clk, arst_n, wr_en, valid_s1 && (kind_s1 == KIND_PIXEL) && hit_s1)
	`FBCK_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !adv_s1, valid_s1 && $stable(color_s1) && $stable(kind_s1))
	`FBCK_ASSERT_NOW(a_no_rw_same, clk, arst_n, valid_s1, !(wr_en && rd_en))

endmodule

`default_nettype wire
